/* sv/sv39_page_table_builder_core_macros.svh */
// Assertion macros shared by the Sv39 page table builder RTL.
`ifndef SV39_PAGE_TABLE_BUILDER_CORE_MACROS_SVH
`define SV39_PAGE_TABLE_BUILDER_CORE_MACROS_SVH

// Checks that cons holds in the same cycle as ante.
`define SV39PTB_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that cons holds in the cycle after ante.
`define SV39PTB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/sv39ptb_pkg.sv */
// Types and constants of the Sv39 page table builder.
package sv39ptb_pkg;

    localparam int TABLE_PAGES       = 64;
    localparam int ENTRIES_PER_TABLE = 512;

    localparam int IDX_W       = $clog2(ENTRIES_PER_TABLE);
    localparam int PAGE_W      = $clog2(TABLE_PAGES);
    localparam int NF_W        = $clog2(TABLE_PAGES + 1);
    localparam int ADDR_W      = PAGE_W + IDX_W;
    localparam int STORE_WORDS = TABLE_PAGES * ENTRIES_PER_TABLE;

    localparam int VPN_W        = 27;
    localparam int PPN_W        = 44;
    localparam int COUNT_W      = 16;
    localparam int PERM_W       = 4;
    localparam int WIDX_W       = 15;
    localparam int WORD_W       = 64;
    localparam int PTE_PPN_LSB  = 10;
    localparam int POOL_PAGES_W = 7;
    localparam int CFG_DATA_W   = 44;
    localparam int CFG_INDEX_W  = 1;

    localparam logic [POOL_PAGES_W-1:0] POOL_PAGES_RESET = 7'd64;

    typedef enum logic [0:0] {
        OP_MAP  = 1'b0,
        OP_READ = 1'b1
    } op_t;

    typedef enum logic [0:0] {
        ST_DONE         = 1'b0,
        ST_OUT_OF_SPACE = 1'b1
    } status_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_POOL_BASE_PPN = 1'b0,
        CFG_POOL_PAGES    = 1'b1
    } cfg_index_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_WALK_RD,
        S_WALK_CHK,
        S_ALLOC_CLR,
        S_PTR_WR,
        S_LEAF_WR
    } state_t;

    typedef struct packed {
        op_t                opcode;
        logic [VPN_W-1:0]   virt_page;
        logic [PPN_W-1:0]   phys_page;
        logic [COUNT_W-1:0] page_count;
        logic [PERM_W-1:0]  perm;
        logic [WIDX_W-1:0]  word_index;
    } cmd_t;

    typedef struct packed {
        status_t            status;
        logic [COUNT_W-1:0] pages_mapped;
        logic [WORD_W-1:0]  read_word;
    } rsp_t;

endpackage

/* sv/sv39ptb_ram.sv */
// Generic single-port synchronous RAM with a registered read.
module sv39ptb_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

/* sv/sv39_page_table_builder_core.sv */
// Top level of the Sv39 page table builder.
// After reset the block holds busy high while it writes zero to every word of the table
// pool in turn; configuration writes are taken during that time. A read word takes the
// registered RAM output in S_READ and returns it as its result. A map word walks its pages
// one by one through a single memory port: at each level it fetches an entry in S_WALK_RD
// and checks it in S_WALK_CHK, and each page ends with the leaf write in S_LEAF_WR. A new
// table is cleared in S_ALLOC_CLR and its pointer written in S_PTR_WR before the walk goes on.
// Each result appears with done for exactly one cycle and cannot be stalled.
module sv39_page_table_builder_core (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       cfg_we,
    input  sv39ptb_pkg::cfg_index_t                    cfg_index,
    input  logic [sv39ptb_pkg::CFG_DATA_W-1:0]         cfg_data,
    input  logic                                       start,
    input  sv39ptb_pkg::cmd_t                          cmd,
    output logic                                       busy,
    output logic                                       done,
    output sv39ptb_pkg::rsp_t                          result
);

    `include "sv39_page_table_builder_core_macros.svh"

    sv39ptb_pkg::state_t state_reg, state_next;
    logic [sv39ptb_pkg::PPN_W-1:0]        pool_base_reg, pool_base_next;
    logic [sv39ptb_pkg::POOL_PAGES_W-1:0] pool_pages_reg, pool_pages_next;
    logic [sv39ptb_pkg::NF_W-1:0]         next_free_reg, next_free_next;
    logic [sv39ptb_pkg::ADDR_W-1:0]       sweep_reg, sweep_next;
    logic [sv39ptb_pkg::VPN_W-1:0]        vpn_reg, vpn_next;
    logic [sv39ptb_pkg::PPN_W-1:0]        ppn_reg, ppn_next;
    logic [sv39ptb_pkg::COUNT_W-1:0]      count_reg, count_next;
    logic [sv39ptb_pkg::PERM_W-1:0]       perm_reg, perm_next;
    logic [sv39ptb_pkg::COUNT_W-1:0]      mapped_reg, mapped_next;
    logic                                 level_reg, level_next;
    logic [sv39ptb_pkg::PAGE_W-1:0]       page_reg, page_next;
    logic [sv39ptb_pkg::ADDR_W-1:0]       wptr_reg, wptr_next;
    logic                                 in_range_reg, in_range_next;
    logic                                 done_reg, done_next;
    sv39ptb_pkg::rsp_t                    result_reg, result_next;

    logic                                 ram_we;
    logic [sv39ptb_pkg::ADDR_W-1:0]       ram_addr;
    logic [sv39ptb_pkg::WORD_W-1:0]       ram_wdata;
    logic [sv39ptb_pkg::WORD_W-1:0]       ram_rdata;

    logic [sv39ptb_pkg::IDX_W-1:0]        walk_idx;
    logic [sv39ptb_pkg::PAGE_W-1:0]       pte_diff;
    logic [sv39ptb_pkg::PPN_W-1:0]        ptr_ppn;
    logic                                 exhausted;

    sv39ptb_ram #(
        .WIDTH (sv39ptb_pkg::WORD_W),
        .DEPTH (sv39ptb_pkg::STORE_WORDS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign walk_idx = level_reg ? vpn_reg[2*sv39ptb_pkg::IDX_W +: sv39ptb_pkg::IDX_W]
                                : vpn_reg[sv39ptb_pkg::IDX_W +: sv39ptb_pkg::IDX_W];
    // The store holds 64 table pages, a power of two, so the page is the low bits of the pointer's offset.
    assign pte_diff = ram_rdata[sv39ptb_pkg::PTE_PPN_LSB +: sv39ptb_pkg::PAGE_W]
                    - pool_base_reg[sv39ptb_pkg::PAGE_W-1:0];
    assign ptr_ppn  = pool_base_reg + sv39ptb_pkg::PPN_W'(page_reg);
    assign exhausted = (32'(next_free_reg) >= 32'(pool_pages_reg))
                    || (32'(next_free_reg) >= 32'(sv39ptb_pkg::TABLE_PAGES));
    assign busy     = (state_reg != sv39ptb_pkg::S_IDLE);
    assign done     = done_reg;
    assign result   = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= sv39ptb_pkg::S_CLEAR;
            pool_base_reg  <= '0;
            pool_pages_reg <= sv39ptb_pkg::POOL_PAGES_RESET;
            next_free_reg  <= sv39ptb_pkg::NF_W'(1);
            sweep_reg      <= '0;
            mapped_reg     <= '0;
            level_reg      <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pool_base_reg  <= pool_base_next;
            pool_pages_reg <= pool_pages_next;
            next_free_reg  <= next_free_next;
            sweep_reg      <= sweep_next;
            mapped_reg     <= mapped_next;
            level_reg      <= level_next;
            done_reg       <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        vpn_reg      <= vpn_next;
        ppn_reg      <= ppn_next;
        count_reg    <= count_next;
        perm_reg     <= perm_next;
        page_reg     <= page_next;
        wptr_reg     <= wptr_next;
        in_range_reg <= in_range_next;
        result_reg   <= result_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        pool_base_next  = pool_base_reg;
        pool_pages_next = pool_pages_reg;
        next_free_next  = next_free_reg;
        sweep_next      = sweep_reg;
        vpn_next        = vpn_reg;
        ppn_next        = ppn_reg;
        count_next      = count_reg;
        perm_next       = perm_reg;
        mapped_next     = mapped_reg;
        level_next      = level_reg;
        page_next       = page_reg;
        wptr_next       = wptr_reg;
        in_range_next   = in_range_reg;
        done_next       = 1'b0;
        result_next     = result_reg;
        ram_we          = 1'b0;
        ram_addr        = sweep_reg;
        ram_wdata       = '0;

        if (cfg_we)
        begin
            case (cfg_index)
                sv39ptb_pkg::CFG_POOL_BASE_PPN: pool_base_next = cfg_data[sv39ptb_pkg::PPN_W-1:0];
                sv39ptb_pkg::CFG_POOL_PAGES:
                    pool_pages_next = cfg_data[sv39ptb_pkg::POOL_PAGES_W-1:0];
                default: ;
            endcase
        end

        case (state_reg)
            sv39ptb_pkg::S_CLEAR:
            begin
                ram_we     = 1'b1;
                sweep_next = sweep_reg + sv39ptb_pkg::ADDR_W'(1);
                if (sweep_reg == sv39ptb_pkg::ADDR_W'(sv39ptb_pkg::STORE_WORDS - 1))
                begin
                    sweep_next = '0;
                    state_next = sv39ptb_pkg::S_IDLE;
                end
            end
            sv39ptb_pkg::S_IDLE:
            begin
                if (start)
                begin
                    if (cmd.opcode == sv39ptb_pkg::OP_READ)
                    begin
                        ram_addr      = sv39ptb_pkg::ADDR_W'(cmd.word_index);
                        in_range_next = 32'(cmd.word_index) < 32'(sv39ptb_pkg::STORE_WORDS);
                        state_next    = sv39ptb_pkg::S_READ;
                    end
                    else
                    begin
                        vpn_next    = cmd.virt_page;
                        ppn_next    = cmd.phys_page;
                        count_next  = cmd.page_count;
                        perm_next   = cmd.perm;
                        mapped_next = '0;
                        level_next  = 1'b1;
                        page_next   = '0;
                        if (cmd.page_count == '0)
                        begin
                            done_next                = 1'b1;
                            result_next.status       = sv39ptb_pkg::ST_DONE;
                            result_next.pages_mapped = '0;
                            result_next.read_word    = '0;
                        end
                        else
                        begin
                            state_next = sv39ptb_pkg::S_WALK_RD;
                        end
                    end
                end
            end
            sv39ptb_pkg::S_READ:
            begin
                done_next                = 1'b1;
                result_next.status       = sv39ptb_pkg::ST_DONE;
                result_next.pages_mapped = '0;
                result_next.read_word    = in_range_reg ? ram_rdata : '0;
                state_next               = sv39ptb_pkg::S_IDLE;
            end
            sv39ptb_pkg::S_WALK_RD:
            begin
                ram_addr   = {page_reg, walk_idx};
                wptr_next  = {page_reg, walk_idx};
                state_next = sv39ptb_pkg::S_WALK_CHK;
            end
            sv39ptb_pkg::S_WALK_CHK:
            begin
                if (ram_rdata[0])
                begin
                    page_next = pte_diff;
                    if (level_reg)
                    begin
                        level_next = 1'b0;
                        state_next = sv39ptb_pkg::S_WALK_RD;
                    end
                    else
                    begin
                        state_next = sv39ptb_pkg::S_LEAF_WR;
                    end
                end
                else if (exhausted)
                begin
                    done_next                = 1'b1;
                    result_next.status       = sv39ptb_pkg::ST_OUT_OF_SPACE;
                    result_next.pages_mapped = mapped_reg;
                    result_next.read_word    = '0;
                    state_next               = sv39ptb_pkg::S_IDLE;
                end
                else
                begin
                    page_next      = next_free_reg[sv39ptb_pkg::PAGE_W-1:0];
                    next_free_next = next_free_reg + sv39ptb_pkg::NF_W'(1);
                    sweep_next     = '0;
                    state_next     = sv39ptb_pkg::S_ALLOC_CLR;
                end
            end
            sv39ptb_pkg::S_ALLOC_CLR:
            begin
                ram_we     = 1'b1;
                ram_addr   = {page_reg, sweep_reg[sv39ptb_pkg::IDX_W-1:0]};
                sweep_next = sweep_reg + sv39ptb_pkg::ADDR_W'(1);
                if (sweep_reg[sv39ptb_pkg::IDX_W-1:0] == '1)
                begin
                    sweep_next = '0;
                    state_next = sv39ptb_pkg::S_PTR_WR;
                end
            end
            sv39ptb_pkg::S_PTR_WR:
            begin
                ram_we    = 1'b1;
                ram_addr  = wptr_reg;
                ram_wdata = {{(sv39ptb_pkg::WORD_W - sv39ptb_pkg::PPN_W
                               - sv39ptb_pkg::PTE_PPN_LSB){1'b0}},
                             ptr_ppn, {(sv39ptb_pkg::PTE_PPN_LSB - 1){1'b0}}, 1'b1};
                if (level_reg)
                begin
                    level_next = 1'b0;
                    state_next = sv39ptb_pkg::S_WALK_RD;
                end
                else
                begin
                    state_next = sv39ptb_pkg::S_LEAF_WR;
                end
            end
            sv39ptb_pkg::S_LEAF_WR:
            begin
                ram_we      = 1'b1;
                ram_addr    = {page_reg, vpn_reg[sv39ptb_pkg::IDX_W-1:0]};
                ram_wdata   = {{(sv39ptb_pkg::WORD_W - sv39ptb_pkg::PPN_W
                                 - sv39ptb_pkg::PTE_PPN_LSB){1'b0}},
                               ppn_reg,
                               {(sv39ptb_pkg::PTE_PPN_LSB - sv39ptb_pkg::PERM_W - 1){1'b0}},
                               perm_reg, 1'b1};
                mapped_next = mapped_reg + sv39ptb_pkg::COUNT_W'(1);
                vpn_next    = vpn_reg + sv39ptb_pkg::VPN_W'(1);
                ppn_next    = ppn_reg + sv39ptb_pkg::PPN_W'(1);
                level_next  = 1'b1;
                page_next   = '0;
                if (mapped_next == count_reg)
                begin
                    done_next                = 1'b1;
                    result_next.status       = sv39ptb_pkg::ST_DONE;
                    result_next.pages_mapped = mapped_next;
                    result_next.read_word    = '0;
                    state_next               = sv39ptb_pkg::S_IDLE;
                end
                else
                begin
                    state_next = sv39ptb_pkg::S_WALK_RD;
                end
            end
            default:
            begin
                state_next = sv39ptb_pkg::S_IDLE;
            end
        endcase
    end

    `SV39PTB_ASSERT_SAME(a_free_bound, 1'b1,
        32'(next_free_reg) <= 32'(sv39ptb_pkg::TABLE_PAGES),
        "Allocator ran past the pool.")
    `SV39PTB_ASSERT_SAME(a_clear_allocated, state_reg == sv39ptb_pkg::S_ALLOC_CLR,
        32'(page_reg) < 32'(next_free_reg),
        "Clearing a table page that was not allocated.")
    `SV39PTB_ASSERT_SAME(a_short_map, done && result.status == sv39ptb_pkg::ST_OUT_OF_SPACE,
        result.pages_mapped != count_reg,
        "Out of space reported after every page was mapped.")
    `SV39PTB_ASSERT_NEXT(a_read_align, state_reg == sv39ptb_pkg::S_WALK_RD,
        state_reg == sv39ptb_pkg::S_WALK_CHK,
        "Entry check does not follow the entry fetch.")

endmodule
